// ===== hw/rtl/mpss_pkg.sv =====
// mpss_pkg: widths, command and status types for the max product subarray core
// shared by mpss_ctrl, mpss_dp and the top level; no dependencies
`default_nettype none
package mpss_pkg;

	localparam int VALUE_BITS   = 16;
	localparam int PRODUCT_BITS = 64;

	localparam int HALF_BITS = PRODUCT_BITS / 2;
	localparam int HI_BITS   = PRODUCT_BITS - HALF_BITS;
	localparam int OPER_BITS = HALF_BITS + 1;
	localparam int MUL_BITS  = OPER_BITS + VALUE_BITS;
	localparam int FULL_BITS = PRODUCT_BITS + VALUE_BITS;
	localparam int CNT_BITS  = $clog2(PRODUCT_BITS);

	typedef struct packed {
		logic latch;
		logic mul_lo;
		logic mul_hi;
		logic sum;
		logic eval;
		logic div_step;
		logic div_end;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic v_zero;
		logic rp_neg;
		logic prefix_none;
	} sts_t;

	function automatic logic [PRODUCT_BITS-1:0] magnitude(input logic [PRODUCT_BITS-1:0] x);
		logic [PRODUCT_BITS-1:0] r;
		r = x[PRODUCT_BITS-1] ? (~x + PRODUCT_BITS'(1)) : x;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mpss_ctrl.sv =====
// mpss_ctrl: sequencing state machine and handshakes for the max product core
// depends on mpss_pkg; drives commands into mpss_dp and reads its status
`default_nettype none
module mpss_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire mpss_pkg::sts_t sts,
	output mpss_pkg::cmd_t      cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MLO  = 3'd1;
	localparam logic [2:0] S_MHI  = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_EVAL = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_DSAT = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0]                    state_q, state_d;
	logic [mpss_pkg::CNT_BITS-1:0] cnt_q;
	logic                          out_valid_q;
	logic                          out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_MLO;
				end
			end
			S_MLO: begin
				cmd.mul_lo = 1'b1;
				state_d    = sts.v_zero ? S_FIN : S_MHI;
			end
			S_MHI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = (sts.rp_neg && !sts.prefix_none) ? S_DIV : S_FIN;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_DSAT;
				end
			end
			S_DSAT: begin
				cmd.div_end = 1'b1;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.eval) begin
				cnt_q <= mpss_pkg::CNT_BITS'(mpss_pkg::PRODUCT_BITS - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - mpss_pkg::CNT_BITS'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mpss_dp.sv =====
// mpss_dp: running product, prefix, best value, shared multiplier and radix-2 divider
// depends on mpss_pkg; steered by commands from mpss_ctrl
`default_nettype none
module mpss_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic signed [mpss_pkg::VALUE_BITS-1:0] value,
	input  wire logic                                  last,
	input  wire mpss_pkg::cmd_t                        cmd,
	output mpss_pkg::sts_t                             sts,
	output logic signed [mpss_pkg::PRODUCT_BITS-1:0]   best_product,
	output logic                                       overflow,
	output logic                                       end_of_sequence
);

	localparam int PW   = mpss_pkg::PRODUCT_BITS;
	localparam int VB   = mpss_pkg::VALUE_BITS;
	localparam int HALF = mpss_pkg::HALF_BITS;
	localparam int OPW  = mpss_pkg::OPER_BITS;
	localparam int MW   = mpss_pkg::MUL_BITS;
	localparam int FW   = mpss_pkg::FULL_BITS;

	logic signed [VB-1:0]  v_q;
	logic                  last_q;
	logic signed [PW-1:0]  rp_q;
	logic signed [PW-1:0]  prefix_q;
	logic signed [PW-1:0]  best_q;
	logic                  at_start_q;
	logic                  ovf_q;
	logic signed [MW-1:0]  pp_lo_q;
	logic signed [MW-1:0]  pp_hi_q;
	logic [PW-1:0]         rem_q;
	logic [PW-1:0]         quo_q;
	logic [PW-1:0]         dvs_q;
	logic signed [PW-1:0]  best_out_q;
	logic                  ovf_out_q;
	logic                  eos_out_q;

	logic signed [OPW-1:0] mul_a;
	logic signed [MW-1:0]  mul_p;
	logic signed [FW-1:0]  lo_ext;
	logic [FW-1:0]         hi_sh;
	logic [FW-1:0]         full;
	logic [FW-PW:0]        top;
	logic                  mul_over;
	logic [PW:0]           trial;
	logic [PW:0]           diff;
	logic                  ge;
	logic                  sat;
	logic signed [PW-1:0]  cand;

	assign mul_a = cmd.mul_hi ? OPW'(signed'(rp_q[PW-1:HALF])) : {1'b0, rp_q[HALF-1:0]};
	assign mul_p = MW'(mul_a) * MW'(v_q);

	assign lo_ext   = FW'(pp_lo_q);
	assign hi_sh    = {pp_hi_q[FW-HALF-1:0], {HALF{1'b0}}};
	assign full     = hi_sh + lo_ext;
	assign top      = full[FW-1:PW-1];
	assign mul_over = !((&top) || !(|top));

	assign trial = {rem_q, quo_q[PW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign sat   = quo_q[PW-1];
	assign cand  = sat ? {1'b0, {(PW-1){1'b1}}} : quo_q;

	assign sts.v_zero      = (v_q == '0);
	assign sts.rp_neg      = rp_q[PW-1];
	assign sts.prefix_none = (prefix_q == '0);

	assign best_product    = best_out_q;
	assign overflow        = ovf_out_q;
	assign end_of_sequence = eos_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q       <= PW'(1);
			prefix_q   <= '0;
			best_q     <= '0;
			at_start_q <= 1'b1;
			ovf_q      <= 1'b0;
		end else begin
			if (cmd.latch && at_start_q) begin
				best_q     <= PW'(value);
				at_start_q <= 1'b0;
			end
			if (cmd.mul_lo && sts.v_zero) begin
				rp_q     <= PW'(1);
				prefix_q <= '0;
			end
			if (cmd.sum) begin
				rp_q <= full[PW-1:0];
				if (mul_over) begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.eval) begin
				if (rp_q[PW-1]) begin
					if (sts.prefix_none) begin
						prefix_q <= rp_q;
					end
				end else if (best_q < rp_q) begin
					best_q <= rp_q;
				end
			end
			if (cmd.div_end) begin
				if (sat) begin
					ovf_q <= 1'b1;
				end
				if (best_q < cand) begin
					best_q <= cand;
				end
			end
			if (cmd.load_out && last_q) begin
				rp_q       <= PW'(1);
				prefix_q   <= '0;
				best_q     <= '0;
				at_start_q <= 1'b1;
				ovf_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			v_q    <= value;
			last_q <= last;
		end
		if (cmd.mul_lo) begin
			pp_lo_q <= mul_p;
		end
		if (cmd.mul_hi) begin
			pp_hi_q <= mul_p;
		end
		if (cmd.eval) begin
			rem_q <= '0;
			quo_q <= mpss_pkg::magnitude(rp_q);
			dvs_q <= mpss_pkg::magnitude(prefix_q);
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[PW-1:0] : trial[PW-1:0];
			quo_q <= {quo_q[PW-2:0], ge};
		end
		if (cmd.load_out) begin
			best_out_q <= best_q;
			ovf_out_q  <= ovf_q;
			eos_out_q  <= last_q;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/max_product_subarray_stream_core.sv =====
// max_product_subarray_stream_core: top level, one result request per input request
// path: a zero goes from low multiply to the result; other values pass both multiplies,
// sum and evaluate; a later negative product is divided by the prefix (64-step radix-2)
// throughput: one request at a time; the next is taken once the sequencer is idle again
// reset: arst_n clears the sequencer, the output valid and the sequence state at once
// depends on mpss_pkg, mpss_ctrl and mpss_dp
`default_nettype none
module max_product_subarray_stream_core (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic signed [mpss_pkg::VALUE_BITS-1:0]  value,
	input  wire logic                                    last,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic signed [mpss_pkg::PRODUCT_BITS-1:0]     best_product,
	output logic                                         overflow,
	output logic                                         end_of_sequence
);

	mpss_pkg::cmd_t cmd;
	mpss_pkg::sts_t sts;

	mpss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mpss_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.value           (value),
		.last            (last),
		.cmd             (cmd),
		.sts             (sts),
		.best_product    (best_product),
		.overflow        (overflow),
		.end_of_sequence (end_of_sequence)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/mpss_chk.sv =====
// mpss_chk: port-level checks on the max product core, bound to the top level
// depends on mpss_pkg and max_product_subarray_stream_core
`default_nettype none
module mpss_chk (
	input wire logic                                   clk,
	input wire logic                                   arst_n,
	input wire logic                                   in_valid,
	input wire logic                                   in_ready,
	input wire logic signed [mpss_pkg::VALUE_BITS-1:0] value,
	input wire logic                                   last,
	input wire logic                                   out_valid,
	input wire logic                                   out_ready,
	input wire logic signed [mpss_pkg::PRODUCT_BITS-1:0] best_product,
	input wire logic                                   overflow,
	input wire logic                                   end_of_sequence
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(best_product)
			&& $stable(overflow) && $stable(end_of_sequence))
		else $error("stalled result changed");

	// one request in flight: in_ready drops after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("request taken while busy");

	// no result appears the cycle after a request is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

endmodule

bind max_product_subarray_stream_core mpss_chk u_chk (.*);
`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for max_product_subarray_stream_core, one request in,
// one result out; directed table then random sequences, checked against a local predictor or the typed row values
// depends on mpss_pkg and the core rtl only
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VB = mpss_pkg::VALUE_BITS;
	localparam int PB = mpss_pkg::PRODUCT_BITS;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CALM_ITEMS = 150;
	localparam int LONG_HOLD = 200;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic signed [PB-1:0] MAX_POS = {1'b0, {(PB-1){1'b1}}};

	typedef struct packed {
		logic signed [PB-1:0] best;
		logic ovf;
		logic eos;
	} run_result_t;

	typedef struct packed {
		logic signed [VB-1:0] v;
		logic l;
		logic typed;
		logic signed [PB-1:0] best;
		logic ovf;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [VB-1:0] value = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [PB-1:0] best_product;
	logic overflow;
	logic end_of_sequence;

	// predictor state
	logic signed [PB-1:0] run_prod;
	logic signed [PB-1:0] neg_prefix;
	logic signed [PB-1:0] best_run;
	bit first_item;
	bit ovf_sticky;

	run_result_t expected[$];
	int sent = 0;
	int seq_count = 0;
	int results_seen = 0;
	int ovf_results = 0;
	int divide_count = 0;
	int mismatches = 0;
	int cycle_count = 0;
	bit idle_on = 1'b1;
	bit calm = 1'b0;
	bit hold_ask = 1'b0;
	bit hold_done = 1'b0;

	stim_row_t directed_rows [23] = '{
		'{16'sd0, 1'b1, 1'b1, 64'sd0, 1'b0},
		'{16'sd32767, 1'b1, 1'b1, 64'sd32767, 1'b0},
		'{-16'sd32768, 1'b1, 1'b1, -64'sd32768, 1'b0},
		'{-16'sd1, 1'b0, 1'b1, -64'sd1, 1'b0},
		'{16'sd16384, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{16'sd16384, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{16'sd16384, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{16'sd16384, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{16'sd128, 1'b1, 1'b1, MAX_POS, 1'b1},
		'{16'sd3, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{16'sd0, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{-16'sd2, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{16'sd5, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{-16'sd4, 1'b1, 1'b0, 64'sd0, 1'b0},
		'{-16'sd32768, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{-16'sd32768, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{-16'sd32768, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{-16'sd32768, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{-16'sd32768, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{16'sd32767, 1'b1, 1'b0, 64'sd0, 1'b0},
		'{16'sd1, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{-16'sd1, 1'b0, 1'b0, 64'sd0, 1'b0},
		'{16'sd0, 1'b1, 1'b0, 64'sd0, 1'b0}
	};

	max_product_subarray_stream_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.best_product(best_product),
		.overflow(overflow),
		.end_of_sequence(end_of_sequence)
	);

	always #1 clk = ~clk;

	function automatic void clear_run();
		run_prod = PB'(1);
		neg_prefix = '0;
		best_run = '0;
		first_item = 1'b1;
		ovf_sticky = 1'b0;
	endfunction

	function automatic run_result_t next_best_product(logic signed [VB-1:0] v, logic l);
		logic signed [2*PB-1:0] wide_a;
		logic signed [2*PB-1:0] wide_b;
		logic signed [2*PB-1:0] wide_p;
		logic signed [2*PB-1:0] back;
		logic [PB-1:0] mag_run;
		logic [PB-1:0] mag_pre;
		logic [PB-1:0] quot;
		run_result_t r;
		if (first_item) begin
			best_run = PB'(v);
			first_item = 1'b0;
		end
		if (v == 0) begin
			run_prod = PB'(1);
			neg_prefix = '0;
		end else begin
			wide_a = (2*PB)'(run_prod);
			wide_b = (2*PB)'(v);
			wide_p = wide_a * wide_b;
			run_prod = wide_p[PB-1:0];
			back = (2*PB)'(run_prod);
			if (back != wide_p)
				ovf_sticky = 1'b1;
			if (run_prod < 0) begin
				if (neg_prefix == 0) begin
					neg_prefix = run_prod;
				end else begin
					mag_run = -run_prod;
					mag_pre = neg_prefix[PB-1] ? -neg_prefix : neg_prefix;
					quot = mag_run / mag_pre;
					divide_count++;
					if (quot > MAX_POS) begin
						ovf_sticky = 1'b1;
						quot = MAX_POS;
					end
					if (best_run < $signed(quot))
						best_run = quot;
				end
			end else if (best_run < run_prod) begin
				best_run = run_prod;
			end
		end
		r.best = best_run;
		r.ovf = ovf_sticky;
		r.eos = l;
		if (l)
			clear_run();
		return r;
	endfunction

	function automatic logic signed [VB-1:0] pick_value();
		int r;
		logic signed [VB-1:0] m;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 45)
			m = VB'($urandom_range(1, 4));
		else if (r < 60)
			m = VB'(1);
		else if (r < 72) begin
			case ($urandom_range(0, 3))
				0: return {1'b1, {(VB-1){1'b0}}};
				1: return {1'b0, {(VB-1){1'b1}}};
				2: return {2'b01, {(VB-2){1'b0}}};
				default: return {2'b11, {(VB-2){1'b0}}};
			endcase
		end else
			return VB'($urandom);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	task automatic send_value(input logic signed [VB-1:0] v, input logic l, input logic typed,
			input logic signed [PB-1:0] t_best, input logic t_ovf);
		run_result_t r;
		in_valid <= 1'b1;
		value <= v;
		last <= l;
		do @(posedge clk); while (!in_ready);
		r = next_best_product(v, l);
		if (typed) begin
			r.best = t_best;
			r.ovf = t_ovf;
		end
		expected.push_back(r);
		sent++;
		if (l)
			seq_count++;
	endtask

	task automatic maybe_gap();
		if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic check_result();
		run_result_t exp_r;
		results_seen++;
		if (overflow)
			ovf_results++;
		if (expected.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result best=%0d ovf=%0b eos=%0b",
					best_product, overflow, end_of_sequence);
			return;
		end
		exp_r = expected.pop_front();
		if (exp_r.best !== best_product || exp_r.ovf !== overflow
				|| exp_r.eos !== end_of_sequence) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: expected best=%0d ovf=%0b eos=%0b, got best=%0d ovf=%0b eos=%0b",
					results_seen, exp_r.best, exp_r.ovf, exp_r.eos,
					best_product, overflow, end_of_sequence);
		end
	endtask

	// result side, with random stalls and one long hold
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_result();
			if (hold_ask && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int n_random;
		int seq_len;
		bit long_run;
		logic signed [VB-1:0] v;
		clear_run();
		n_random = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_value(directed_rows[i].v, directed_rows[i].l, directed_rows[i].typed,
				directed_rows[i].best, directed_rows[i].ovf);
			maybe_gap();
		end

		// drain fully before the random part
		in_valid <= 1'b0;
		do @(posedge clk); while (expected.size() != 0);

		while (n_random < RANDOM_ITEMS) begin
			long_run = ($urandom_range(0, 9) == 0);
			seq_len = long_run ? $urandom_range(30, 60) : $urandom_range(1, 16);
			idle_on = ($urandom_range(0, 4) != 0);
			calm = (n_random >= RANDOM_ITEMS - CALM_ITEMS);
			if (n_random >= 600)
				hold_ask = 1'b1;
			for (int k = 0; k < seq_len; k++) begin
				if (long_run) begin
					v = VB'($urandom_range(1, 3));
					if ($urandom_range(0, 1))
						v = -v;
				end else begin
					v = pick_value();
				end
				send_value(v, k == seq_len - 1, 1'b0, '0, 1'b0);
				n_random++;
				maybe_gap();
			end
		end
		in_valid <= 1'b0;

		while (expected.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("%0d requests over %0d sequences, %0d results checked", sent, seq_count,
			results_seen);
		$display("%0d results used prefix division, %0d carried the overflow flag",
			divide_count, ovf_results);
		if (mismatches == 0 && expected.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
